FILE: hdl/bfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfg_pkg;

    localparam int CURVE_POINTS  = 16;
    localparam int AVG_DEPTH     = 8;
    localparam int UPDATE_PERIOD = 10;
    localparam int PERCENT_STEP  = 5;

    localparam int POINT_DIST = 256 / CURVE_POINTS;
    localparam int CRV_AW     = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
    localparam int RING_AW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int RING_CW    = $clog2(AVG_DEPTH + 1);
    localparam int RING_SW    = 8 + RING_CW;
    localparam int HOLD_W     = 4;
    localparam int DIV_NUM_W  = 24;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_CW     = $clog2(DIV_NUM_W + 1);
    localparam int PCT_MUL    = 100 / PERCENT_STEP;
    localparam int NUM_COEF   = 6;

    // status reading ranges, tested in this order
    localparam logic [7:0] NONE_LO  = 8'd130;
    localparam logic [7:0] NONE_HI  = 8'd210;
    localparam logic [7:0] CHG_LO   = 8'd4;
    localparam logic [7:0] CHG_HI   = 8'd62;
    localparam logic [7:0] FULL_LO  = 8'd211;
    localparam logic [7:0] FULL_HI  = 8'd255;
    localparam logic [7:0] DSCH_LO  = 8'd0;
    localparam logic [7:0] DSCH_HI  = 8'd3;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_CHARGING    = 3'd1,
        ST_CHARGED     = 3'd2,
        ST_DISCHARGING = 3'd3,
        ST_UNKNOWN     = 3'd4
    } bat_status_t;

    typedef enum logic [2:0] {
        CFG_COEF_CONTRAST_SQ    = 3'd0,
        CFG_COEF_COLOR_CONTRAST = 3'd1,
        CFG_COEF_COLOR_SQ       = 3'd2,
        CFG_COEF_CONTRAST       = 3'd3,
        CFG_COEF_COLOR          = 3'd4,
        CFG_COEF_BIAS           = 3'd5,
        CFG_PERCENT_GAIN        = 3'd6,
        CFG_PERCENT_OFFSET      = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_V,
        S_LOAD_M,
        S_LOAD_FIN,
        S_CRV_MID,
        S_CRV_CMP,
        S_DIV_LVL,
        S_CORR,
        S_PUSH,
        S_PUSH_W,
        S_DIV_AVG,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  status_reading;
        logic [15:0] level_sample;
        logic [7:0]  contrast;
        logic [7:0]  avg_color;
        logic [3:0]  point_index;
        logic [15:0] point_lower;
        logic [15:0] point_span;
    } in_item_t;

    typedef struct packed {
        logic [2:0] battery_status;
        logic       updated;
        logic [7:0] corrected_level;
        logic [7:0] average_level;
        logic [6:0] battery_percent;
        logic       low_battery;
    } out_item_t;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic [7:0] level;
    } ring_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [RING_SW-1:0] sum;
        logic [RING_CW-1:0] count;
    } ring_stat_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic bat_status_t classify(input logic [7:0] r);
        bat_status_t s;
        priority if (r >= NONE_LO && r <= NONE_HI) s = ST_NONE;
        else if (r >= CHG_LO && r <= CHG_HI)       s = ST_CHARGING;
        else if (r >= FULL_LO && r <= FULL_HI)     s = ST_CHARGED;
        else if (r >= DSCH_LO && r <= DSCH_HI)     s = ST_DISCHARGING;
        else                                       s = ST_UNKNOWN;
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/bfg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bfg_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bfg_pkg::div_req_t req,
    output bfg_pkg::div_rsp_t      rsp
);

    logic [bfg_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [bfg_pkg::DIV_DEN_W:0]   rem_reg, rem_next;
    logic [bfg_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [bfg_pkg::DIV_CW-1:0]    cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [bfg_pkg::DIV_DEN_W:0]   shifted;
    logic [bfg_pkg::DIV_DEN_W+1:0] trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[bfg_pkg::DIV_DEN_W-1:0], num_reg[bfg_pkg::DIV_NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = bfg_pkg::DIV_CW'(bfg_pkg::DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[bfg_pkg::DIV_DEN_W+1])
            begin
                rem_next = trial[bfg_pkg::DIV_DEN_W:0];
                num_next = {num_reg[bfg_pkg::DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                num_next = {num_reg[bfg_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bfg_pkg::DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // zero divisor gives zero
    assign rsp.done = done_reg;
    assign rsp.quo  = (den_reg == '0) ? '0 : num_reg;

endmodule
`default_nettype wire

FILE: hdl/bfg_ring.sv
`timescale 1ns / 1ps
`default_nettype none
module bfg_ring (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bfg_pkg::ring_ctrl_t ctrl,
    output bfg_pkg::ring_stat_t      stat
);

    logic [7:0] mem [bfg_pkg::AVG_DEPTH];

    logic [bfg_pkg::RING_AW-1:0] head_reg, head_next;
    logic [bfg_pkg::RING_CW-1:0] count_reg, count_next;
    logic [bfg_pkg::RING_SW-1:0] sum_reg, sum_next;
    logic                        phase_reg, phase_next;
    logic                        done_reg, done_next;
    logic [7:0]                  level_reg;
    logic [7:0]                  old_reg;
    logic                        full;
    logic [7:0]                  evict;

    // oldest entry is read under head and replaced in the following cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            old_reg   <= mem[head_reg];
            level_reg <= ctrl.level;
        end
        if (phase_reg)
        begin
            mem[head_reg] <= level_reg;
        end
    end

    assign full  = (count_reg == bfg_pkg::RING_CW'(bfg_pkg::AVG_DEPTH));
    assign evict = full ? old_reg : 8'd0;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        phase_next = ctrl.push;
        done_next  = 1'b0;
        if (ctrl.clear)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (phase_reg)
        begin
            sum_next  = sum_reg + bfg_pkg::RING_SW'(level_reg) - bfg_pkg::RING_SW'(evict);
            done_next = 1'b1;
            if (head_reg == bfg_pkg::RING_AW'(bfg_pkg::AVG_DEPTH - 1))
                head_next = '0;
            else
                head_next = head_reg + 1'b1;
            if (!full)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    assign stat.done  = done_reg;
    assign stat.sum   = sum_reg;
    assign stat.count = count_reg;

endmodule
`default_nettype wire

FILE: hdl/battery_fuel_gauge_estimator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Battery fuel gauge estimator.
// Input channel in_valid/in_stall/in_data: mode 1 writes one discharge curve
// point, mode 0 takes a status reading and voltage sample. Every item yields
// exactly one result on out_valid/out_stall/out_data.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the load
// coefficients, gain and offset; cfg_ready is always high. Write only while idle.
// Curve writes and samples that do not update go from idle through the done
// state to the output register. An updating sample passes through the load
// estimate (one multiply per term), the curve search (one read of the curve
// memory per point visited), the interpolation divide when it is needed,
// correction and the ring read-modify-write, the averaging divide and the
// load of the output register.
// One item is worked on at a time; the next is taken once the result sits in
// the output register, even while the receiver stalls it.
// Reset: status unknown, average, ring count and update holdoff zero; curve
// memory and level ring hold garbage until written.
module battery_fuel_gauge_estimator_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bfg_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bfg_pkg::out_item_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    logic [31:0] curve_mem [bfg_pkg::CURVE_POINTS];
    logic [31:0] curve_rdata_reg;

    logic signed [15:0] coef_reg [bfg_pkg::NUM_COEF];
    logic signed [7:0]  gain_reg;
    logic signed [7:0]  offset_reg;

    bfg_pkg::state_t       state_reg, state_next;
    bfg_pkg::bat_status_t  status_reg, status_next;
    logic [bfg_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [7:0]  avg_reg, avg_next;
    logic        updated_reg, updated_next;
    logic        out_valid_reg, out_valid_next;
    bfg_pkg::out_item_t out_reg, out_next;

    logic [15:0] sample_reg, sample_next;
    logic [7:0]  contrast_reg, contrast_next;
    logic [7:0]  color_reg, color_next;
    logic [2:0]  k_reg, k_next;
    logic [15:0] vprod_reg, vprod_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  load_reg, load_next;
    logic [bfg_pkg::CRV_AW-1:0] idx_reg, idx_next;
    logic [15:0] mid_reg, mid_next;
    logic [15:0] prev_reg, prev_next;
    logic [7:0]  base_reg, base_next;
    logic [7:0]  level_reg, level_next;
    logic [7:0]  corr_reg, corr_next;

    logic                       crv_rd;
    logic [bfg_pkg::CRV_AW-1:0] crv_addr;
    logic                       in_xfer;
    logic                       out_xfer;

    bfg_pkg::ring_ctrl_t ring_ctrl;
    bfg_pkg::ring_stat_t ring_stat;
    bfg_pkg::div_req_t   div_req;
    bfg_pkg::div_rsp_t   div_rsp;

    logic [7:0]         opa, opb;
    logic signed [32:0] lprod;
    logic [23:0]        span_load;
    logic [15:0]        diff;
    logic               diff_pos;
    logic signed [16:0] cprod;
    logic signed [10:0] adj;
    logic [15:0]        pct_acc;
    logic [15:0]        pct_full;
    bfg_pkg::bat_status_t cls;

    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != bfg_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfg_pkg::NUM_COEF; i++)
                coef_reg[i] <= '0;
            gain_reg   <= '0;
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bfg_pkg::cfg_reg_t'(cfg_index))
                bfg_pkg::CFG_PERCENT_GAIN:   gain_reg   <= cfg_data[7:0];
                bfg_pkg::CFG_PERCENT_OFFSET: offset_reg <= cfg_data[7:0];
                default:                     coef_reg[cfg_index] <= cfg_data;
            endcase
        end
    end

    // curve memory: written by mode 1 transfers, read during the search
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.mode &&
            (32'(in_data.point_index) < bfg_pkg::CURVE_POINTS))
        begin
            curve_mem[bfg_pkg::CRV_AW'(in_data.point_index)] <=
                {in_data.point_lower, in_data.point_span};
        end
        if (crv_rd)
        begin
            curve_rdata_reg <= curve_mem[crv_addr];
        end
    end

    bfg_ring u_ring (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ring_ctrl),
        .stat (ring_stat)
    );

    bfg_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    always_comb
    begin
        unique case (k_reg)
            3'd0:    begin opa = contrast_reg; opb = contrast_reg; end
            3'd1:    begin opa = color_reg;    opb = contrast_reg; end
            3'd2:    begin opa = color_reg;    opb = color_reg;    end
            3'd3:    begin opa = contrast_reg; opb = 8'd1;         end
            3'd4:    begin opa = color_reg;    opb = 8'd1;         end
            default: begin opa = 8'd1;         opb = 8'd1;         end
        endcase
    end

    assign lprod     = $signed({1'b0, vprod_reg}) * coef_reg[k_reg];
    assign span_load = curve_rdata_reg[15:0] * load_reg;
    assign diff      = sample_reg - mid_reg;
    assign diff_pos  = !diff[15] && (diff != 16'd0);
    assign cprod     = gain_reg * $signed({1'b0, level_reg});
    assign adj       = $signed({3'b000, level_reg}) + $signed({{2{cprod[16]}}, cprod[16:8]})
                     + $signed({{3{offset_reg[7]}}, offset_reg});
    assign pct_acc   = 16'(avg_next) * 16'(bfg_pkg::PCT_MUL) + 16'd255;
    assign pct_full  = 16'(pct_acc[15:8]) * 16'(bfg_pkg::PERCENT_STEP);
    assign cls       = bfg_pkg::classify(in_data.status_reading);

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        hold_next      = hold_reg;
        avg_next       = avg_reg;
        updated_next   = updated_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        out_next       = out_reg;
        sample_next    = sample_reg;
        contrast_next  = contrast_reg;
        color_next     = color_reg;
        k_next         = k_reg;
        vprod_next     = vprod_reg;
        acc_next       = acc_reg;
        load_next      = load_reg;
        idx_next       = idx_reg;
        mid_next       = mid_reg;
        prev_next      = prev_reg;
        base_next      = base_reg;
        level_next     = level_reg;
        corr_next      = corr_reg;
        crv_rd         = 1'b0;
        crv_addr       = idx_reg;
        ring_ctrl      = '0;
        ring_ctrl.level = corr_reg;
        div_req        = '0;

        unique case (state_reg)
            bfg_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    updated_next  = 1'b0;
                    corr_next     = 8'd0;
                    sample_next   = in_data.level_sample;
                    contrast_next = in_data.contrast;
                    color_next    = in_data.avg_color;
                    state_next    = bfg_pkg::S_DONE;
                    if (!in_data.mode)
                    begin
                        status_next = cls;
                        if (cls != bfg_pkg::ST_DISCHARGING)
                        begin
                            avg_next        = 8'd0;
                            hold_next       = '0;
                            ring_ctrl.clear = 1'b1;
                        end
                        else if (hold_reg != '0)
                        begin
                            hold_next = hold_reg - 1'b1;
                        end
                        else
                        begin
                            hold_next    = bfg_pkg::HOLD_W'(bfg_pkg::UPDATE_PERIOD - 1);
                            updated_next = 1'b1;
                            k_next       = 3'd0;
                            acc_next     = 16'd0;
                            state_next   = bfg_pkg::S_LOAD_V;
                        end
                    end
                end
            end

            bfg_pkg::S_LOAD_V:
            begin
                vprod_next = 16'(opa * opb);
                state_next = bfg_pkg::S_LOAD_M;
            end

            bfg_pkg::S_LOAD_M:
            begin
                acc_next = acc_reg + lprod[23:8];
                if (k_reg == 3'(bfg_pkg::NUM_COEF - 1))
                begin
                    state_next = bfg_pkg::S_LOAD_FIN;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = bfg_pkg::S_LOAD_V;
                end
            end

            bfg_pkg::S_LOAD_FIN:
            begin
                if (acc_reg[15])
                    load_next = 8'd255;
                else if (acc_reg[14:11] != 4'd0)
                    load_next = 8'd0;
                else
                    load_next = 8'd255 - acc_reg[10:3];
                idx_next   = '0;
                crv_rd     = 1'b1;
                crv_addr   = '0;
                base_next  = 8'(256 - bfg_pkg::POINT_DIST);
                state_next = bfg_pkg::S_CRV_MID;
            end

            bfg_pkg::S_CRV_MID:
            begin
                mid_next   = curve_rdata_reg[31:16] + span_load[23:8];
                state_next = bfg_pkg::S_CRV_CMP;
            end

            bfg_pkg::S_CRV_CMP:
            begin
                if (diff_pos)
                begin
                    if (idx_reg == '0)
                    begin
                        level_next = bfg_pkg::LEVEL_MAX;
                        state_next = bfg_pkg::S_CORR;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = bfg_pkg::DIV_NUM_W'(diff[14:0])
                                      * bfg_pkg::DIV_NUM_W'(bfg_pkg::POINT_DIST);
                        div_req.den   = prev_reg - mid_reg;
                        state_next    = bfg_pkg::S_DIV_LVL;
                    end
                end
                else
                begin
                    prev_next = mid_reg;
                    base_next = base_reg - 8'(bfg_pkg::POINT_DIST);
                    if (idx_reg == bfg_pkg::CRV_AW'(bfg_pkg::CURVE_POINTS - 1))
                    begin
                        level_next = 8'd0;
                        state_next = bfg_pkg::S_CORR;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        crv_rd     = 1'b1;
                        crv_addr   = idx_reg + 1'b1;
                        state_next = bfg_pkg::S_CRV_MID;
                    end
                end
            end

            bfg_pkg::S_DIV_LVL:
            begin
                if (div_rsp.done)
                begin
                    level_next = div_rsp.quo[7:0] + base_reg;
                    state_next = bfg_pkg::S_CORR;
                end
            end

            bfg_pkg::S_CORR:
            begin
                if (adj[10])
                    corr_next = 8'd0;
                else if (adj[9:8] != 2'd0)
                    corr_next = 8'd255;
                else
                    corr_next = adj[7:0];
                state_next = bfg_pkg::S_PUSH;
            end

            bfg_pkg::S_PUSH:
            begin
                ring_ctrl.push = 1'b1;
                state_next     = bfg_pkg::S_PUSH_W;
            end

            bfg_pkg::S_PUSH_W:
            begin
                if (ring_stat.done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = bfg_pkg::DIV_NUM_W'(ring_stat.sum);
                    div_req.den   = bfg_pkg::DIV_DEN_W'(ring_stat.count);
                    state_next    = bfg_pkg::S_DIV_AVG;
                end
            end

            bfg_pkg::S_DIV_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quo[7:0];
                    state_next = bfg_pkg::S_DONE;
                end
            end

            bfg_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_next.battery_status  = status_reg;
                    out_next.updated         = updated_reg;
                    out_next.corrected_level = corr_reg;
                    out_next.average_level   = avg_reg;
                    out_next.battery_percent = pct_full[6:0];
                    out_next.low_battery     = (status_reg == bfg_pkg::ST_DISCHARGING)
                                             && (avg_reg == 8'd0);
                    state_next               = bfg_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bfg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfg_pkg::S_IDLE;
            status_reg    <= bfg_pkg::ST_UNKNOWN;
            hold_reg      <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            hold_reg      <= hold_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        updated_reg  <= updated_next;
        sample_reg   <= sample_next;
        contrast_reg <= contrast_next;
        color_reg    <= color_next;
        k_reg        <= k_next;
        vprod_reg    <= vprod_next;
        acc_reg      <= acc_next;
        load_reg     <= load_next;
        idx_reg      <= idx_next;
        mid_reg      <= mid_next;
        prev_reg     <= prev_next;
        base_reg     <= base_next;
        level_reg    <= level_next;
        corr_reg     <= corr_next;
    end

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != bfg_pkg::S_IDLE))
        else $error("no work started after input transfer");

    a_low_needs_dsch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.low_battery ||
                       out_data.battery_status == bfg_pkg::ST_DISCHARGING))
        else $error("low battery flagged while not discharging");

    a_ring_count: assert property (@(posedge clk) disable iff (!rst_n)
        ring_stat.count <= bfg_pkg::RING_CW'(bfg_pkg::AVG_DEPTH))
        else $error("ring count beyond depth");

    a_no_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.updated) |-> (out_data.corrected_level == 8'd0))
        else $error("corrected level without update");

endmodule
`default_nettype wire
